// ===== rtl/wspd_pkg.sv =====
// Package for the weather sensor pulse decoder.
// Holds the frame constants, register indexes and the result status codes.
// Used by the channel interfaces and the top level; depends on nothing.
package wspd_pkg;

  localparam int unsigned TicksW     = 8;
  localparam int unsigned ScaleW     = 8;
  localparam int unsigned ThreshW    = 16;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned IdxW       = 8;
  localparam int unsigned WordW      = 32;
  localparam int unsigned ChkW       = 4;

  localparam logic [IdxW-1:0]    FramePulses  = 8'd74;
  localparam logic [IdxW-1:0]    IdxMax       = 8'd255;
  localparam logic [ScaleW-1:0]  ScaleReset   = 8'd25;
  localparam logic [ThreshW-1:0] ThreshReset  = 16'd2560;

  // The nine-bit direction field is divided by 45 as (v * 729) >> 15.
  localparam logic [9:0]         DirRecip     = 10'd729;
  localparam int unsigned        DirShift     = 15;

  localparam logic [CfgIdxW-1:0] RegPulseScale = 2'd0;
  localparam logic [CfgIdxW-1:0] RegThreshold  = 2'd1;

  typedef enum logic [2:0] {
    ST_LEN_ERR  = 3'd0,
    ST_CHK_ERR  = 3'd1,
    ST_TEMP_HUM = 3'd2,
    ST_RAIN     = 3'd3,
    ST_WIND_SPD = 3'd4,
    ST_WIND_DIR = 3'd5,
    ST_OTHER    = 3'd6
  } status_e;

endpackage

// ===== rtl/wspd_pulse_if.sv =====
// Channel interface carrying one pulse request into the decoder.
// Depends on wspd_pkg for the field widths.
interface wspd_pulse_if;
  import wspd_pkg::*;

  logic              valid;
  logic              ready;
  logic [TicksW-1:0] pulse_ticks;
  logic              last_pulse;

  modport source (output valid, output pulse_ticks, output last_pulse, input ready);
  modport sink   (input valid, input pulse_ticks, input last_pulse, output ready);
endinterface

// ===== rtl/wspd_result_if.sv =====
// Channel interface carrying one decoded frame request out of the decoder.
// Depends on wspd_pkg for the status codes.
interface wspd_result_if;
  import wspd_pkg::*;

  logic               valid;
  logic               ready;
  status_e            status;
  logic [7:0]         sensor_id;
  logic signed [11:0] temperature;
  logic [7:0]         humidity;
  logic [15:0]        rain;
  logic [7:0]         wind_speed;
  logic [7:0]         wind_gust;
  logic [3:0]         wind_direction;

  modport source (
    output valid, output status, output sensor_id, output temperature,
    output humidity, output rain, output wind_speed, output wind_gust,
    output wind_direction, input ready
  );
  modport sink (
    input valid, input status, input sensor_id, input temperature,
    input humidity, input rain, input wind_speed, input wind_gust,
    input wind_direction, output ready
  );
endinterface

// ===== rtl/weather_sensor_pulse_decoder.sv =====
// Top level of the weather sensor pulse decoder.
// Depends on wspd_pkg, wspd_pulse_if and wspd_result_if.
//
// The decoder accepts one pulse request per clock cycle while the input is not stalled.
// Each pulse is scaled by an 8x8 multiply and compared with the threshold; the bits of
// even pulses 2 to 64 are shifted into the frame word and those of even pulses 66 to 72
// into the checksum, in the cycle the pulse is accepted. A pulse marked last captures
// the frame into a holding register; from there the length and checksum are checked
// and the frame decoded, and the result register is loaded once it is free. A waiting
// result stalls the input only when a second finished frame is already held behind it.
module weather_sensor_pulse_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wspd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [wspd_pkg::CfgDataW-1:0] cfg_wdata_i,
  wspd_pulse_if.sink                    pulse_i,
  wspd_result_if.source                 result_o
);
  import wspd_pkg::*;

  typedef struct packed {
    status_e            status;
    logic [7:0]         sensor_id;
    logic signed [11:0] temperature;
    logic [7:0]         humidity;
    logic [15:0]        rain;
    logic [7:0]         wind_speed;
    logic [7:0]         wind_gust;
    logic [3:0]         wind_direction;
  } result_t;

  logic [ScaleW-1:0]  scale_q;
  logic [ThreshW-1:0] thresh_q;

  logic [IdxW-1:0]  idx_q, idx_d;
  logic [WordW-1:0] word_q, word_d;
  logic [ChkW-1:0]  chk_q, chk_d;

  logic             frm_valid_q;
  logic [WordW-1:0] frm_word_q;
  logic [ChkW-1:0]  frm_chk_q;
  logic             frm_len_ok_q;

  logic    res_valid_q;
  result_t res_q, res_d;

  logic in_acc, frm_adv, res_free, bit_one;
  logic [ThreshW-1:0] product;

  assign res_free      = !res_valid_q || result_o.ready;
  assign frm_adv       = frm_valid_q && res_free;
  assign pulse_i.ready = !frm_valid_q || res_free;
  assign in_acc        = pulse_i.valid && pulse_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= ScaleReset;
      thresh_q <= ThreshReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegPulseScale) begin
        scale_q <= cfg_wdata_i[ScaleW-1:0];
      end else if (cfg_idx_i == RegThreshold) begin
        thresh_q <= cfg_wdata_i[ThreshW-1:0];
      end
    end
  end

  assign product = ThreshW'(pulse_i.pulse_ticks) * ThreshW'(scale_q);
  assign bit_one = product > thresh_q;

  always_comb begin
    idx_d  = (idx_q == IdxMax) ? IdxMax : idx_q + 8'd1;
    word_d = word_q;
    chk_d  = chk_q;
    if (!idx_d[0]) begin
      if (idx_d inside {[8'd2:8'd64]}) begin
        word_d = {bit_one, word_q[WordW-1:1]};
      end else if (idx_d inside {[8'd66:8'd72]}) begin
        chk_d = {bit_one, chk_q[ChkW-1:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      word_q <= '0;
      chk_q  <= '0;
    end else if (in_acc) begin
      if (pulse_i.last_pulse) begin
        idx_q  <= '0;
        word_q <= '0;
        chk_q  <= '0;
      end else begin
        idx_q  <= idx_d;
        word_q <= word_d;
        chk_q  <= chk_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frm_valid_q <= 1'b0;
    end else if (in_acc && pulse_i.last_pulse) begin
      frm_valid_q <= 1'b1;
    end else if (frm_adv) begin
      frm_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && pulse_i.last_pulse) begin
      frm_word_q   <= word_d;
      frm_chk_q    <= chk_d;
      frm_len_ok_q <= idx_d == FramePulses;
    end
  end

  logic [3:0]  nib [8];
  logic [3:0]  sum4, calc;
  logic        rain_type, type_bits;
  logic [18:0] dir_prod;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      nib[k] = frm_word_q[4*k +: 4];
    end
    sum4 = '0;
    for (int k = 0; k < 8; k++) begin
      sum4 = sum4 + nib[k];
    end
    type_bits = (nib[2] & 4'h6) == 4'h6;
    rain_type = type_bits && (nib[3] == 4'd3);
    calc      = rain_type ? 4'd7 + sum4 : 4'd15 - sum4;
    dir_prod  = 19'(frm_word_q[23:15]) * 19'(DirRecip);

    res_d = '0;
    if (!frm_len_ok_q) begin
      res_d.status = ST_LEN_ERR;
    end else if (calc != frm_chk_q) begin
      res_d.status = ST_CHK_ERR;
    end else begin
      res_d.sensor_id = frm_word_q[7:0];
      if (!type_bits) begin
        res_d.status      = ST_TEMP_HUM;
        res_d.temperature = frm_word_q[23:12];
        res_d.humidity    = {1'b0, nib[7], 3'b0} + {3'b0, nib[7], 1'b0} + {4'b0, nib[6]};
      end else if (nib[3] == 4'd3) begin
        res_d.status = ST_RAIN;
        res_d.rain   = frm_word_q[31:16];
      end else if (nib[3] == 4'd1) begin
        res_d.status     = ST_WIND_SPD;
        res_d.wind_speed = frm_word_q[31:24];
      end else if (nib[3][2:0] == 3'd7) begin
        res_d.status         = ST_WIND_DIR;
        res_d.wind_gust      = frm_word_q[31:24];
        res_d.wind_direction = dir_prod[DirShift +: 4];
      end else begin
        res_d.status = ST_OTHER;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_free) begin
      res_valid_q <= frm_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frm_adv) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid          = res_valid_q;
  assign result_o.status         = res_q.status;
  assign result_o.sensor_id      = res_q.sensor_id;
  assign result_o.temperature    = res_q.temperature;
  assign result_o.humidity       = res_q.humidity;
  assign result_o.rain           = res_q.rain;
  assign result_o.wind_speed     = res_q.wind_speed;
  assign result_o.wind_gust      = res_q.wind_gust;
  assign result_o.wind_direction = res_q.wind_direction;

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && pulse_i.last_pulse |=> idx_q == '0 && word_q == '0 && chk_q == '0)
    else $error("frame state not cleared after last pulse");

  a_index_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !pulse_i.last_pulse && idx_q != IdxMax |=> idx_q == $past(idx_q) + 8'd1)
    else $error("pulse index did not advance");

  a_dir_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> res_q.wind_direction <= 4'd11)
    else $error("wind direction out of range");

  a_error_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && (res_q.status == ST_LEN_ERR || res_q.status == ST_CHK_ERR)
      |-> res_q.sensor_id == '0)
    else $error("error result carries a sensor id");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the weather sensor pulse decoder.
// It drives pulse trains, predicts every decoded frame and compares the results.
// Depends on wspd_pkg, wspd_pulse_if, wspd_result_if and weather_sensor_pulse_decoder.
module testbench;
  import wspd_pkg::*;

  localparam logic [CfgIdxW-1:0] RegSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpareB = 2'd3;

  typedef struct packed {
    status_e            status;
    logic [7:0]         sensor_id;
    logic signed [11:0] temperature;
    logic [7:0]         humidity;
    logic [15:0]        rain;
    logic [7:0]         wind_speed;
    logic [7:0]         wind_gust;
    logic [3:0]         wind_direction;
  } frame_result_t;

  typedef enum {K_TEMP_HUM, K_RAIN, K_WIND_SPD, K_WIND_DIR, K_OTHER} frame_kind_e;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  wspd_pulse_if  pulse_if ();
  wspd_result_if result_if ();

  weather_sensor_pulse_decoder u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .pulse_i     (pulse_if),
    .result_o    (result_if)
  );

  logic [ScaleW-1:0]  scale_q;
  logic [ThreshW-1:0] thresh_q;
  logic [IdxW-1:0]    pulse_num;
  logic [WordW-1:0]   frame_word;
  logic [ChkW-1:0]    frame_chk;

  frame_result_t expected_frames[$];
  int frames_predicted = 0;
  int sent_pulses = 0;
  int mismatches = 0;
  int hold_cycles = 0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("testbench NOT OK");
    $finish;
  end

  function automatic logic [ChkW-1:0] frame_check(input logic [WordW-1:0] w);
    int sum = 0;
    for (int k = 0; k < 8; k++) sum += w[4*k +: 4];
    if (w[10:9] == 2'b11 && w[15:12] == 4'd3) return 4'(7 + sum);
    return 4'(15 - sum);
  endfunction

  function automatic void decode_pulse(input logic [TicksW-1:0] ticks, input logic is_last);
    logic [15:0] scaled;
    logic one;
    frame_result_t r;
    if (pulse_num != IdxMax) pulse_num++;
    scaled = ticks * scale_q;
    one = scaled > thresh_q;
    if (!pulse_num[0]) begin
      if (pulse_num >= 2 && pulse_num <= 64) begin
        frame_word = {one, frame_word[31:1]};
      end else if (pulse_num >= 66 && pulse_num <= 72) begin
        frame_chk = {one, frame_chk[3:1]};
      end
    end
    if (!is_last) return;
    r = '0;
    r.status = ST_LEN_ERR;
    if (pulse_num != FramePulses) begin
      r.status = ST_LEN_ERR;
    end else if (frame_check(frame_word) != frame_chk) begin
      r.status = ST_CHK_ERR;
    end else begin
      r.sensor_id = frame_word[7:0];
      if (frame_word[10:9] != 2'b11) begin
        r.status = ST_TEMP_HUM;
        r.temperature = frame_word[23:12];
        r.humidity = 8'(10 * frame_word[31:28] + frame_word[27:24]);
      end else if (frame_word[15:12] == 4'd3) begin
        r.status = ST_RAIN;
        r.rain = frame_word[31:16];
      end else if (frame_word[15:12] == 4'd1) begin
        r.status = ST_WIND_SPD;
        r.wind_speed = frame_word[31:24];
      end else if (frame_word[14:12] == 3'd7) begin
        r.status = ST_WIND_DIR;
        r.wind_gust = frame_word[31:24];
        r.wind_direction = 4'(frame_word[23:15] / 45);
      end else begin
        r.status = ST_OTHER;
      end
    end
    expected_frames.push_back(r);
    frames_predicted++;
    pulse_num = '0;
    frame_word = '0;
    frame_chk = '0;
  endfunction

  function automatic void check_field(input string field, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    frame_result_t want;
    if (result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
      if (expected_frames.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0d", $time,
                 result_if.status);
        mismatches++;
      end else begin
        want = expected_frames.pop_front();
        check_field("status", want.status, result_if.status);
        check_field("sensor_id", want.sensor_id, result_if.sensor_id);
        check_field("temperature", want.temperature, result_if.temperature);
        check_field("humidity", want.humidity, result_if.humidity);
        check_field("rain", want.rain, result_if.rain);
        check_field("wind_speed", want.wind_speed, result_if.wind_speed);
        check_field("wind_gust", want.wind_gust, result_if.wind_gust);
        check_field("wind_direction", want.wind_direction, result_if.wind_direction);
      end
    end
  end

  initial begin
    int stall;
    result_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        result_if.ready = 1'b0;
        while (hold_cycles > 0) begin
          @(negedge clk);
          hold_cycles--;
        end
      end
      stall = rx_idle_on ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        result_if.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_if.ready = 1'b1;
      do @(posedge clk); while (result_if.valid !== 1'b1);
      @(negedge clk);
    end
  end

  task automatic send_pulse(input logic [TicksW-1:0] ticks, input logic is_last);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      pulse_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pulse_if.valid = 1'b1;
    pulse_if.pulse_ticks = ticks;
    pulse_if.last_pulse = is_last;
    do @(posedge clk); while (pulse_if.ready !== 1'b1);
    decode_pulse(ticks, is_last);
    sent_pulses++;
    @(negedge clk);
  endtask

  // Lengths near the threshold are favored so that the strict compare is exercised.
  function automatic logic [TicksW-1:0] pick_ticks(input logic one);
    int unsigned knee;
    knee = thresh_q / scale_q;
    if (one) begin
      if (knee >= 255) return 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) return 8'(knee + 1);
      return 8'($urandom_range(knee + 1, 255));
    end
    if (knee > 255) knee = 255;
    if ($urandom_range(0, 3) == 0) return 8'(knee);
    return 8'($urandom_range(0, knee));
  endfunction

  task automatic send_frame(input logic [WordW-1:0] word, input logic [ChkW-1:0] chk,
                            input int len);
    logic [TicksW-1:0] ticks;
    for (int n = 1; n <= len; n++) begin
      if (n % 2 == 0 && n <= 64) begin
        ticks = pick_ticks(word[n/2-1]);
      end else if (n % 2 == 0 && n >= 66 && n <= 72) begin
        ticks = pick_ticks(chk[(n-66)/2]);
      end else begin
        ticks = 8'($urandom_range(0, 255));
      end
      send_pulse(ticks, n == len);
    end
  endtask

  task automatic send_valid_frame(input logic [WordW-1:0] word);
    send_frame(word, frame_check(word), FramePulses);
  endtask

  function automatic logic [WordW-1:0] make_word(input frame_kind_e kind);
    logic [WordW-1:0] w;
    logic [3:0] n3;
    w = $urandom;
    if (kind == K_TEMP_HUM) begin
      w[10:9] = 2'($urandom_range(0, 2));
      return w;
    end
    w[10:9] = 2'b11;
    case (kind)
      K_RAIN: begin
        w[15:12] = 4'd3;
      end
      K_WIND_SPD: begin
        w[15:12] = 4'd1;
      end
      K_WIND_DIR: begin
        w[15:12] = {1'($urandom_range(0, 1)), 3'd7};
      end
      default: begin
        do n3 = 4'($urandom); while (n3 == 4'd1 || n3 == 4'd3 || n3[2:0] == 3'd7);
        w[15:12] = n3;
      end
    endcase
    return w;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      RegPulseScale: scale_q = data[ScaleW-1:0];
      RegThreshold:  thresh_q = data[ThreshW-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    pulse_if.valid = 1'b0;
    while (expected_frames.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic set_config(input int scale, input int thresh);
    wait_drained();
    write_reg(RegPulseScale, {8'($urandom), 8'(scale)});
    write_reg(RegThreshold, 16'(thresh));
  endtask

  task automatic test_frame_types();
    send_valid_frame(32'hFF80_0034);
    send_valid_frame(32'hFFFF_3600);
    send_valid_frame(32'hFF00_1655);
    send_valid_frame(32'h12FF_F6CD);
    send_valid_frame(32'hFFFF_E7FF);
  endtask

  task automatic test_checksum_errors();
    logic [WordW-1:0] w;
    w = 32'h1234_3600;
    send_frame(w, frame_check(w) ^ 4'h1, FramePulses);
  endtask

  task automatic test_length_errors();
    logic [WordW-1:0] w;
    w = make_word(K_RAIN);
    send_frame(w, frame_check(w), 1);
    send_frame(w, frame_check(w), 73);
    send_frame(w, frame_check(w), 260);
  endtask

  task automatic test_threshold_edges();
    set_config(255, 65023);
    send_valid_frame(make_word(K_OTHER));
    set_config(1, 65535);
    send_valid_frame(make_word(K_RAIN));
    set_config(16, 2560);
    write_reg(RegSpareA, 16'($urandom));
    write_reg(RegSpareB, 16'($urandom));
    send_valid_frame(make_word(K_WIND_DIR));
    set_config(25, 2560);
  endtask

  task automatic test_backpressure();
    wait_drained();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_cycles = 80;
    for (int i = 0; i < 10; i++) send_pulse(8'($urandom_range(0, 255)), 1'b1);
    send_valid_frame(make_word(K_WIND_SPD));
    send_pulse(8'($urandom_range(0, 255)), 1'b1);
    wait_drained();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_random();
    int frame_goal;
    int frames_in_phase;
    int scale;
    int thresh;
    int pick;
    logic [WordW-1:0] w;
    frame_goal = frames_predicted + 3;
    frames_in_phase = 0;
    while (frames_predicted < frame_goal) begin
      if (frames_in_phase == 0) begin
        pick = $urandom_range(0, 9);
        scale = (pick == 0) ? 1 : (pick == 1) ? 255 : $urandom_range(1, 255);
        pick = $urandom_range(0, 11);
        if (pick == 0) thresh = 0;
        else if (pick == 1) thresh = 65535;
        else thresh = scale * $urandom_range(30, 220) + $urandom_range(0, scale - 1);
        if (thresh > 65535) thresh = 65535;
        set_config(scale, thresh);
        tx_idle_on = $urandom_range(0, 3) != 0;
        rx_idle_on = $urandom_range(0, 3) != 0;
        frames_in_phase = $urandom_range(4, 8);
      end
      frames_in_phase--;
      pick = $urandom_range(0, 99);
      w = make_word(frame_kind_e'($urandom_range(0, 4)));
      if (pick < 70) begin
        send_valid_frame(w);
      end else if (pick < 80) begin
        send_frame(w, frame_check(w) ^ 4'($urandom_range(1, 15)), FramePulses);
      end else if (pick < 88) begin
        send_frame(w, frame_check(w), $urandom_range(1, 2) == 1 ?
                   $urandom_range(1, 73) : $urandom_range(75, 100));
      end else if (pick < 91) begin
        send_frame(w, frame_check(w), $urandom_range(200, 270));
      end else begin
        send_frame($urandom, 4'($urandom), $urandom_range(60, 80));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = RegPulseScale;
    cfg_wdata = '0;
    pulse_if.valid = 1'b0;
    pulse_if.pulse_ticks = '0;
    pulse_if.last_pulse = 1'b0;
    scale_q = ScaleReset;
    thresh_q = ThreshReset;
    pulse_num = '0;
    frame_word = '0;
    frame_chk = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_frame_types();
    test_checksum_errors();
    test_length_errors();
    test_threshold_edges();
    test_backpressure();
    test_random();

    wait_drained();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
